@@ hw/rtl/lc4_pkg.sv @@
package lc4_pkg;

  localparam logic [15:0] RESET_PC     = 16'h8200;
  localparam logic [15:0] USER_CODE_HI = 16'h2000;
  localparam logic [15:0] OS_CODE_LO   = 16'h8000;
  localparam logic [15:0] OS_CODE_HI   = 16'hA000;

  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_HALT    = 4'd1;
  localparam logic [3:0] ST_UJUMP   = 4'd2;
  localparam logic [3:0] ST_OSJUMP  = 4'd3;
  localparam logic [3:0] ST_DATAEX  = 4'd4;
  localparam logic [3:0] ST_CODEADR = 4'd5;
  localparam logic [3:0] ST_PRIV    = 4'd6;
  localparam logic [3:0] ST_BADOP   = 4'd7;
  localparam logic [3:0] ST_STOPPED = 4'd8;

  localparam logic [3:0] OP_BR    = 4'd0;
  localparam logic [3:0] OP_ARITH = 4'd1;
  localparam logic [3:0] OP_CMP   = 4'd2;
  localparam logic [3:0] OP_JSR   = 4'd4;
  localparam logic [3:0] OP_LOGIC = 4'd5;
  localparam logic [3:0] OP_LDR   = 4'd6;
  localparam logic [3:0] OP_STR   = 4'd7;
  localparam logic [3:0] OP_RTI   = 4'd8;
  localparam logic [3:0] OP_CONST = 4'd9;
  localparam logic [3:0] OP_SHIFT = 4'd10;
  localparam logic [3:0] OP_JMP   = 4'd12;
  localparam logic [3:0] OP_HICON = 4'd13;
  localparam logic [3:0] OP_TRAP  = 4'd15;

  // queued request between front and back
  typedef struct packed {
    logic        preload;
    logic [15:0] instruction;
    logic [15:0] addr;
    logic [15:0] value;
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_EXEC, S_DIV, S_MEM, S_DONE
  } state_t;

endpackage

@@ hw/rtl/lc4_instruction_execute_unit.sv @@
// Requests pass from the queue through IDLE, EXEC and DONE; legal loads and
// stores add a MEM state (registered memory read), and DIV/MOD by a nonzero divisor
// adds a DIV state (one quotient bit per cycle). One request runs at a time, and
// DONE waits while the last result is not yet taken; a preload gives no result.
// Reset is synchronous: after rst falls the 64K data memory is swept to zero
// before requests are taken.
module lc4_instruction_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start_pc_we,
  input  logic [15:0] start_pc,
  input  logic        push,
  output logic        full,
  input  logic        operation,
  input  logic [15:0] instruction,
  input  logic [15:0] preload_address,
  input  logic [15:0] preload_value,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] instr_pc,
  output logic        reg_write,
  output logic [2:0]  reg_number,
  output logic [15:0] reg_value,
  output logic        nzp_write,
  output logic [2:0]  nzp_value,
  output logic        mem_write,
  output logic [15:0] mem_address,
  output logic [15:0] mem_value,
  output logic [15:0] next_pc,
  output logic [3:0]  status
);
  import lc4_pkg::*;

  req_t in_req, q_data;
  logic q_empty, q_pop;

  assign in_req = '{preload: operation, instruction: instruction,
                    addr: preload_address, value: preload_value};

  // front: request queue
  lc4_queue u_queue (
    .clk(clk), .rst(rst), .wr_en(push), .wr_data(in_req), .full(full),
    .rd_en(q_pop), .rd_data(q_data), .empty(q_empty)
  );

  // back: execute sequencer
  lc4_back u_back (
    .clk(clk), .rst(rst), .start_pc_we(start_pc_we), .start_pc_data(start_pc),
    .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .empty(empty), .pop(pop), .instr_pc(instr_pc), .reg_write(reg_write),
    .reg_number(reg_number), .reg_value(reg_value), .nzp_write(nzp_write),
    .nzp_value(nzp_value), .mem_write(mem_write), .mem_address(mem_address),
    .mem_value(mem_value), .next_pc(next_pc), .status(status)
  );
endmodule

@@ hw/rtl/lc4_queue.sv @@
module lc4_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  lc4_pkg::req_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output lc4_pkg::req_t rd_data,
  output logic          empty
);
  import lc4_pkg::*;

  req_t       slot [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full    = cnt == 2'd2;
  assign empty   = cnt == 2'd0;
  assign rd_data = slot[rp];

  // two-entry ring
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_en && !full) wp <= ~wp;
      if (rd_en && !empty) rp <= ~rp;
      cnt <= cnt + 2'(wr_en && !full) - 2'(rd_en && !empty);
    end
    if (wr_en && !full) slot[wp] <= wr_data;
  end
endmodule

@@ hw/rtl/lc4_divider.sv @@
module lc4_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient,
  output logic [15:0] remainder
);
  logic [15:0] q, r, d;
  logic [4:0]  cnt;
  logic        busy;
  logic [16:0] trial;

  assign trial     = {r, q[15]} - {1'b0, d};
  assign quotient  = q;
  assign remainder = r;

  // restoring divide, one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      q <= dividend;
      r <= 16'd0;
      d <= divisor;
    end else if (busy) begin
      if (!trial[16]) begin
        r <= trial[15:0];
        q <= {q[14:0], 1'b1};
      end else begin
        r <= {r[14:0], q[15]};
        q <= {q[14:0], 1'b0};
      end
    end
  end
endmodule

@@ hw/rtl/lc4_back.sv @@
module lc4_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          start_pc_we,
  input  logic [15:0]   start_pc_data,
  input  logic          q_empty,
  input  lc4_pkg::req_t q_data,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [15:0]   instr_pc,
  output logic          reg_write,
  output logic [2:0]    reg_number,
  output logic [15:0]   reg_value,
  output logic          nzp_write,
  output logic [2:0]    nzp_value,
  output logic          mem_write,
  output logic [15:0]   mem_address,
  output logic [15:0]   mem_value,
  output logic [15:0]   next_pc,
  output logic [3:0]    status
);
  import lc4_pkg::*;

  logic [15:0] mem [65536];
  logic [15:0] regs [8];
  logic [15:0] pc;
  logic        priv, stopped;
  logic [2:0]  flags;
  state_t      state, state_next;
  logic [16:0] clr_addr;
  logic [15:0] mem_rd;
  req_t        cur;

  // result register
  logic        out_valid;
  logic [15:0] o_ipc, o_rv, o_ma, o_mv, o_npc;
  logic        o_rw, o_nw, o_mw;
  logic [2:0]  o_rn, o_nv;
  logic [3:0]  o_st;

  assign empty = !out_valid;
  assign instr_pc = o_ipc; assign reg_write = o_rw; assign reg_number = o_rn;
  assign reg_value = o_rv; assign nzp_write = o_nw; assign nzp_value = o_nv;
  assign mem_write = o_mw; assign mem_address = o_ma; assign mem_value = o_mv;
  assign next_pc = o_npc; assign status = o_st;

  // decode of current instruction
  logic [15:0] ins, a, b, x, npc1;
  logic [3:0]  op;
  logic [2:0]  rd, rs, rt, sub3;
  logic [1:0]  sub2;
  assign ins  = cur.instruction;
  assign op   = ins[15:12];
  assign rd   = ins[11:9];
  assign rs   = ins[8:6];
  assign rt   = ins[2:0];
  assign sub3 = ins[5:3];
  assign sub2 = ins[5:4];
  assign a    = regs[rs];
  assign b    = regs[rt];
  assign x    = regs[rd];
  assign npc1 = pc + 16'd1;

  logic [15:0] imm5, imm6, imm7, imm9, imm11;
  assign imm5  = {{11{ins[4]}}, ins[4:0]};
  assign imm6  = {{10{ins[5]}}, ins[5:0]};
  assign imm7  = {{9{ins[6]}}, ins[6:0]};
  assign imm9  = {{7{ins[8]}}, ins[8:0]};
  assign imm11 = {{5{ins[10]}}, ins[10:0]};

  logic [31:0] prod;
  assign prod = a * b;

  // divider shared by DIV and MOD
  logic        div_start, div_done;
  logic [15:0] quo, rem;
  lc4_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(a), .divisor(b),
    .done(div_done), .quotient(quo), .remainder(rem)
  );

  function automatic logic [2:0] rel3(input logic lt, input logic eq);
    rel3 = lt ? 3'd4 : (eq ? 3'd2 : 3'd1);
  endfunction

  function automatic logic [2:0] nzp_of(input logic [15:0] v);
    nzp_of = (v == 16'd0) ? 3'd2 : (v[15] ? 3'd4 : 3'd1);
  endfunction

  logic is_div;
  assign is_div = (op == OP_ARITH && sub3 == 3'd3) ||
                  (op == OP_SHIFT && sub2 == 2'd3);

  // combinational execute of everything but divide results and load data
  logic        e_wreg, e_wnzp, e_wmem, e_shown, e_setpriv, e_newpriv;
  logic [2:0]  e_rnum, e_nzp;
  logic [15:0] e_v, e_addr, e_mval, e_npc, jt;
  logic [3:0]  e_st;
  logic        pc_data, pc_user, pc_os;
  assign pc_user = pc < USER_CODE_HI;
  assign pc_os   = pc >= OS_CODE_LO && pc < OS_CODE_HI;
  assign pc_data = (pc >= USER_CODE_HI && pc < OS_CODE_LO) || pc >= OS_CODE_HI;

  always_comb begin
    e_wreg = 1'b0; e_wnzp = 1'b0; e_wmem = 1'b0; e_shown = 1'b0;
    e_setpriv = 1'b0; e_newpriv = 1'b0;
    e_rnum = rd; e_nzp = 3'd0; e_v = 16'd0; e_addr = 16'd0; e_mval = 16'd0;
    e_npc = npc1; e_st = ST_OK; jt = 16'd0;
    case (op)
      OP_BR: if ((rd & flags) != 3'd0) e_npc = npc1 + imm9;
      OP_ARITH: begin
        e_wreg = 1'b1;
        case (sub3)
          3'd0: e_v = a + b;
          3'd1: e_v = prod[15:0];
          3'd2: e_v = a - b;
          3'd3: e_v = x;
          default: e_v = a + imm5;
        endcase
      end
      OP_CMP: begin
        e_wnzp = 1'b1;
        case (ins[8:7])
          2'd0: e_nzp = rel3($signed(x) < $signed(b), x == b);
          2'd1: e_nzp = rel3(x < b, x == b);
          2'd2: e_nzp = rel3($signed(x) < $signed(imm7), x == imm7);
          default: e_nzp = rel3(x < {9'd0, ins[6:0]}, x == {9'd0, ins[6:0]});
        endcase
      end
      OP_JSR, OP_JMP: begin
        if (op == OP_JSR) begin
          e_wreg = 1'b1; e_rnum = 3'd7; e_v = npc1;
        end
        if (ins[11]) begin
          if (op == OP_JSR) jt = {pc[15], 15'd0} | {imm11[11:0], 4'd0};
          else jt = npc1 + imm11;
        end else begin
          jt = a;
        end
        e_npc = jt;
        if (pc_user && jt >= USER_CODE_HI) e_st = ST_UJUMP;
        else if (pc_os && (jt < OS_CODE_LO || jt >= OS_CODE_HI)) e_st = ST_OSJUMP;
      end
      OP_LOGIC: begin
        e_wreg = 1'b1;
        case (sub3)
          3'd0: e_v = a & b;
          3'd1: e_v = ~a;
          3'd2: e_v = a | b;
          3'd3: e_v = a ^ b;
          default: e_v = a & imm5;
        endcase
      end
      OP_LDR, OP_STR: begin
        e_addr = a + imm6;
        if (pc_data) e_st = ST_DATAEX;
        else if (e_addr < USER_CODE_HI ||
                 (e_addr >= OS_CODE_LO && e_addr < OS_CODE_HI)) e_st = ST_CODEADR;
        else if (!priv && e_addr >= OS_CODE_LO) e_st = ST_PRIV;
        else begin
          e_shown = 1'b1;
          if (op == OP_LDR) e_wreg = 1'b1;
          else begin
            e_wmem = 1'b1; e_mval = x;
          end
        end
      end
      OP_RTI: begin
        e_npc = regs[7]; e_setpriv = 1'b1; e_newpriv = 1'b0;
      end
      OP_CONST: begin
        e_wreg = 1'b1; e_v = imm9;
      end
      OP_SHIFT: begin
        e_wreg = 1'b1;
        case (sub2)
          2'd0: e_v = a << ins[3:0];
          2'd1: e_v = 16'($signed(a) >>> ins[3:0]);
          2'd2: e_v = a >> ins[3:0];
          default: e_v = x;
        endcase
      end
      OP_HICON: begin
        e_wreg = 1'b1; e_v = {ins[7:0], x[7:0]};
      end
      OP_TRAP: begin
        e_wreg = 1'b1; e_rnum = 3'd7; e_v = npc1;
        if (ins[7:0] == 8'hFF) begin
          e_st = ST_HALT; e_npc = pc;
        end else begin
          e_npc = {8'h80, ins[7:0]}; e_setpriv = 1'b1; e_newpriv = 1'b1;
        end
      end
      default: e_st = ST_BADOP;
    endcase
  end

  // pending execute results held across divide / load wait
  logic        p_wreg, p_wnzp, p_wmem, p_shown, p_setpriv, p_newpriv;
  logic [2:0]  p_rnum, p_nzp;
  logic [15:0] p_v, p_addr, p_mval, p_npc, p_pc;
  logic [3:0]  p_st;

  // final values for commit, chosen by state
  logic [15:0] f_v, f_mval;
  logic [2:0]  f_nzp;
  logic        div_zero;
  assign div_zero = b == 16'd0;
  always_comb begin
    f_v = p_v; f_mval = p_mval; f_nzp = p_nzp;
    if (state == S_DIV && b != 16'd0) f_v = (ins[15:12] == OP_ARITH) ? quo : rem;
    if (state == S_MEM && !p_wmem) begin
      f_v = mem_rd; f_mval = mem_rd;
    end
    if (p_wreg && op != OP_JSR) f_nzp = nzp_of(f_v);
  end

  logic can_take;
  assign can_take = !out_valid || pop;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr[16]) state_next = S_IDLE;
      S_IDLE: if (!q_empty) state_next = S_EXEC;
      S_EXEC: begin
        if (cur.preload || stopped || e_st >= ST_UJUMP) state_next = S_DONE;
        else if (is_div && !div_zero) state_next = S_DIV;
        else if (e_shown) state_next = S_MEM;
        else state_next = S_DONE;
      end
      S_DIV: if (div_done) state_next = S_DONE;
      S_MEM: state_next = S_DONE;
      S_DONE: if (p_st == ST_STOPPED + 4'd1 || can_take) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  assign q_pop     = state == S_IDLE && !q_empty;
  assign div_start = state == S_EXEC && !cur.preload && !stopped &&
                     e_st < ST_UJUMP && is_div && !div_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= 17'd0;
      pc       <= RESET_PC;
      priv     <= 1'b1;
      flags    <= 3'd2;
      stopped  <= 1'b0;
      out_valid <= 1'b0;
      p_st     <= ST_OK;
      for (int i = 0; i < 8; i++) regs[i] <= 16'd0;
    end else begin
      state <= state_next;
      if (start_pc_we) begin
        pc <= start_pc_data;
      end
      if (state == S_CLEAR) clr_addr <= clr_addr + 17'd1;
      if (state == S_IDLE && !q_empty) cur <= q_data;
      if (state == S_EXEC) begin
        p_setpriv <= e_setpriv; p_newpriv <= e_newpriv; p_rnum <= e_rnum;
        p_nzp <= (e_wreg && op != OP_JSR) ? nzp_of(e_v) : e_nzp;
        p_v <= e_v; p_addr <= e_addr; p_mval <= e_mval; p_pc <= pc;
        if (!cur.preload && !stopped && e_st < ST_UJUMP) begin
          p_wreg <= e_wreg; p_wnzp <= e_wnzp || (e_wreg && op != OP_JSR);
          p_wmem <= e_wmem; p_shown <= e_shown; p_npc <= e_npc; p_st <= e_st;
        end else begin
          p_wreg <= 1'b0; p_wnzp <= 1'b0; p_wmem <= 1'b0; p_shown <= 1'b0;
          p_npc <= pc;
          if (cur.preload) p_st <= ST_STOPPED + 4'd1;
          else if (stopped) p_st <= ST_STOPPED;
          else begin
            p_st <= e_st; stopped <= 1'b1;
          end
        end
      end
      // divide / load results, then output and architectural update at commit
      if (state == S_DIV || state == S_MEM) begin
        p_v <= f_v; p_mval <= f_mval; p_nzp <= f_nzp;
      end
      if (state == S_DONE && p_st != ST_STOPPED + 4'd1 && can_take) begin
        out_valid <= 1'b1;
        o_ipc <= p_pc; o_rw <= p_wreg; o_rn <= p_wreg ? p_rnum : 3'd0;
        o_rv <= p_wreg ? p_v : 16'd0; o_nw <= p_wnzp;
        o_nv <= p_wnzp ? p_nzp : 3'd0; o_mw <= p_wmem;
        o_ma <= p_shown ? p_addr : 16'd0; o_mv <= p_shown ? p_mval : 16'd0;
        o_npc <= p_npc; o_st <= p_st;
        if (p_st == ST_OK || p_st == ST_HALT) begin
          if (p_wreg) regs[p_rnum] <= p_v;
          if (p_wnzp) flags <= p_nzp;
          if (p_setpriv) priv <= p_newpriv;
          pc <= p_npc;
          if (p_st == ST_HALT) stopped <= 1'b1;
        end
      end else if (out_valid && pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // data memory: clear sweep, preload, store; registered read
  always_ff @(posedge clk) begin
    if (state == S_CLEAR && !clr_addr[16]) mem[clr_addr[15:0]] <= 16'd0;
    else if (state == S_EXEC && cur.preload) mem[cur.addr] <= cur.value;
    else if (state == S_DONE && p_wmem && p_st == ST_OK && can_take)
      mem[p_addr] <= p_mval;
    mem_rd <= mem[e_addr];
  end
endmodule
